### hw/rtl/slp_packet_deframer_top_assert.svh
// Assertion macros shared by the deframer checker.
`ifndef SLP_PACKET_DEFRAMER_TOP_ASSERT_SVH
`define SLP_PACKET_DEFRAMER_TOP_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define SLP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");
// Next-cycle implication, disabled during reset.
`define SLP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer assertion failed");
`endif

### hw/rtl/slp_pkg.sv
// Package with the deframer's shared constants and codes.
package slp_pkg;
   localparam logic [7:0] PRE_0 = 8'hbe;
   localparam logic [7:0] PRE_1 = 8'hef;
   localparam logic [7:0] PRE_2 = 8'hed;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [1:0] PH_HUNT = 2'd0;
   localparam logic [1:0] PH_HEAD = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;
   localparam logic [1:0] PH_CRC  = 2'd3;

   localparam logic [3:0] POS_DEST   = 4'd3;
   localparam logic [3:0] POS_SRC    = 4'd4;
   localparam logic [3:0] POS_TYPE   = 4'd5;
   localparam logic [3:0] POS_SIZE_H = 4'd6;
   localparam logic [3:0] POS_SIZE_L = 4'd7;
   localparam logic [3:0] POS_XID    = 4'd8;
   localparam logic [3:0] POS_SUM    = 4'd9;

   localparam logic REG_LOCAL_PORT     = 1'b0;
   localparam logic REG_LOCAL_PROTOCOL = 1'b1;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   function automatic logic [7:0] preamble_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0: val = PRE_0;
         2'd1: val = PRE_1;
         default: val = PRE_2;
      endcase
      return val;
   endfunction
endpackage

### hw/rtl/slp_crc16.sv
// One byte step of the CRC-16 with polynomial 0x1021, MSB first.
module slp_crc16 (
   input  logic [15:0] crc_in_val,
   input  logic [7:0]  data,
   output logic [15:0] crc_out_val
);
   always_comb begin
      logic [15:0] c;
      c = crc_in_val ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ slp_pkg::CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      crc_out_val = c;
   end
endmodule

### hw/rtl/slp_packet_deframer_top.sv
// Top level of the serial link packet deframer.
// The req channel carries one received link byte per beat. The block hunts
// for the preamble, parses and checks the ten-byte header, and for packets
// whose type and destination match the csr registers it sends each body byte
// as a data beat on the rsp channel, followed by an end beat that carries the
// CRC-16 check result. Packets for other ports or protocols produce no beats.
// Every rsp beat also carries the source, type, transaction id and length.
// Each byte is processed in the cycle it is accepted, and its beat, if any,
// appears in the output register on the next cycle. One byte can be accepted
// every cycle while req_stall is low. req_stall is raised only while the
// output register holds a beat and rsp_stall is high, so a stalled receiver
// holds the input back with no loss. The csr registers are written through
// csr_we, csr_index and csr_wdata and should be changed only while idle.
// Synchronous reset clears the registers, returns the parser to the preamble
// hunt and empties the output register.
module slp_packet_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_crc_ok,
   output logic [7:0]  rsp_source_port,
   output logic [7:0]  rsp_packet_type,
   output logic [7:0]  rsp_transaction_id,
   output logic [15:0] rsp_body_length,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);
   logic [7:0]  local_port_ff, local_protocol_ff;
   logic [1:0]  phase_ff, phase_in;
   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  dest_ff, dest_in, src_ff, src_in, type_ff, type_in, xid_ff, xid_in;
   logic [15:0] size_ff, size_in, remain_ff, remain_in, crc_ff, crc_in;
   logic [7:0]  sum_ff, sum_in;
   logic        ignore_ff, ignore_in;

   logic        rsp_valid_ff;
   logic        kind_ff, kind_in, ok_ff, ok_in;
   logic [7:0]  data_ff, data_in;
   logic        rsp_load;

   logic        accept;
   logic [1:0]  hunt_idx;
   logic [15:0] crc_seed, crc_next;
   logic [7:0]  b;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign b         = req_rx_byte;
   assign hunt_idx  = (pos_ff > 4'd2) ? 2'd0 : pos_ff[1:0];
   assign crc_seed  = (phase_ff == slp_pkg::PH_HUNT && hunt_idx == 2'd0) ? 16'h0000 : crc_ff;

   slp_crc16 u_crc (
      .crc_in_val  (crc_seed),
      .data        (b),
      .crc_out_val (crc_next)
   );

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      dest_in   = dest_ff;
      src_in    = src_ff;
      type_in   = type_ff;
      xid_in    = xid_ff;
      size_in   = size_ff;
      remain_in = remain_ff;
      crc_in    = crc_ff;
      sum_in    = sum_ff;
      ignore_in = ignore_ff;
      rsp_load  = 1'b0;
      kind_in   = slp_pkg::KIND_DATA;
      data_in   = 8'h00;
      ok_in     = 1'b0;
      if (accept) begin
         case (phase_ff)
            slp_pkg::PH_HUNT: begin
               if (b == slp_pkg::preamble_byte(hunt_idx)) begin
                  sum_in = ((hunt_idx == 2'd0) ? 8'h00 : sum_ff) + b;
                  crc_in = crc_next;
                  pos_in = {2'b00, hunt_idx} + 4'd1;
                  if (hunt_idx == 2'd2) begin
                     phase_in = slp_pkg::PH_HEAD;
                  end
               end else begin
                  pos_in = 4'd0;
               end
            end
            slp_pkg::PH_HEAD: begin
               crc_in = crc_next;
               if (pos_ff < slp_pkg::POS_SUM) begin
                  sum_in = sum_ff + b;
                  pos_in = pos_ff + 4'd1;
               end
               case (pos_ff)
                  slp_pkg::POS_DEST:   dest_in = b;
                  slp_pkg::POS_SRC:    src_in = b;
                  slp_pkg::POS_TYPE:   type_in = b;
                  slp_pkg::POS_SIZE_H: size_in = {b, size_ff[7:0]};
                  slp_pkg::POS_SIZE_L: size_in = {size_ff[15:8], b};
                  slp_pkg::POS_XID:    xid_in = b;
                  default: begin
                     pos_in = 4'd0;
                     if (b != sum_ff) begin
                        phase_in = slp_pkg::PH_HUNT;
                     end else begin
                        ignore_in = !(type_ff == local_protocol_ff && dest_ff == local_port_ff);
                        remain_in = size_ff;
                        phase_in  = (size_ff != 16'h0000) ? slp_pkg::PH_BODY : slp_pkg::PH_CRC;
                     end
                  end
               endcase
            end
            slp_pkg::PH_BODY: begin
               crc_in    = crc_next;
               remain_in = remain_ff - 16'd1;
               if (remain_ff == 16'd1) begin
                  phase_in = slp_pkg::PH_CRC;
                  pos_in   = 4'd0;
               end
               if (!ignore_ff) begin
                  rsp_load = 1'b1;
                  kind_in  = slp_pkg::KIND_DATA;
                  data_in  = b;
               end
            end
            default: begin
               crc_in = crc_next;
               pos_in = pos_ff + 4'd1;
               if (pos_ff != 4'd0) begin
                  phase_in = slp_pkg::PH_HUNT;
                  pos_in   = 4'd0;
                  if (!ignore_ff) begin
                     rsp_load = 1'b1;
                     kind_in  = slp_pkg::KIND_END;
                     ok_in    = (crc_next == 16'h0000);
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_port_ff     <= 8'h00;
         local_protocol_ff <= 8'h00;
         phase_ff          <= slp_pkg::PH_HUNT;
         pos_ff            <= 4'd0;
         dest_ff           <= 8'h00;
         src_ff            <= 8'h00;
         type_ff           <= 8'h00;
         xid_ff            <= 8'h00;
         size_ff           <= 16'h0000;
         remain_ff         <= 16'h0000;
         crc_ff            <= 16'h0000;
         sum_ff            <= 8'h00;
         ignore_ff         <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_we && csr_index == slp_pkg::REG_LOCAL_PORT) begin
            local_port_ff <= csr_wdata;
         end
         if (csr_we && csr_index == slp_pkg::REG_LOCAL_PROTOCOL) begin
            local_protocol_ff <= csr_wdata;
         end
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         dest_ff   <= dest_in;
         src_ff    <= src_in;
         type_ff   <= type_in;
         xid_ff    <= xid_in;
         size_ff   <= size_in;
         remain_ff <= remain_in;
         crc_ff    <= crc_in;
         sum_ff    <= sum_in;
         ignore_ff <= ignore_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         kind_ff <= kind_in;
         data_ff <= data_in;
         ok_ff   <= ok_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_data_byte      = data_ff;
   assign rsp_crc_ok         = ok_ff;
   assign rsp_source_port    = src_ff;
   assign rsp_packet_type    = type_ff;
   assign rsp_transaction_id = xid_ff;
   assign rsp_body_length    = size_ff;
endmodule

### hw/rtl/slp_checker.sv
// Port-level checker for the deframer, bound to the top level.
`include "slp_packet_deframer_top_assert.svh"
module slp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_kind,
   input logic [7:0]  rsp_data_byte,
   input logic        rsp_crc_ok
);
   logic [9:0] rsp_payload;
   logic       rsp_end;

   assign rsp_payload = {rsp_kind, rsp_data_byte, rsp_crc_ok};
   assign rsp_end     = (rsp_kind == slp_pkg::KIND_END);

   `SLP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `SLP_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload))
   `SLP_ASSERT_IMP(a_stall_only_full, clock, reset, req_stall, rsp_valid && rsp_stall)
   `SLP_ASSERT_IMP(a_end_no_data, clock, reset, rsp_valid && rsp_end, rsp_data_byte == 8'h00)
   `SLP_ASSERT_IMP(a_data_no_ok, clock, reset, rsp_valid && !rsp_end, !rsp_crc_ok)
endmodule

bind slp_packet_deframer_top slp_checker u_slp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_kind      (rsp_kind),
   .rsp_data_byte (rsp_data_byte),
   .rsp_crc_ok    (rsp_crc_ok)
);

### bench/slp_packet_deframer_top_test.sv
// Self-checking bench for the packet deframer: byte stream stimulus, predicted beats, compare.
module slp_packet_deframer_top_test;

   localparam int IDLE_PCT    = 27;
   localparam int ITEM_GOAL   = 550;
   localparam int BEAT_GOAL   = 48;
   localparam int HOLD_CYCLES = 250;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic        kind;
      logic [7:0]  data_byte;
      logic        crc_ok;
      logic [7:0]  source_port;
      logic [7:0]  packet_type;
      logic [7:0]  transaction_id;
      logic [15:0] body_length;
   } beat_type;

   class deframer_scoreboard_type;
      beat_type    expected_beats[$];
      int          errors;
      int          beats_seen;
      logic [7:0]  port_reg;
      logic [7:0]  proto_reg;
      logic [7:0]  sync_pattern[3];
      logic [1:0]  phase;
      logic [3:0]  pos;
      logic [7:0]  dest;
      logic [7:0]  src;
      logic [7:0]  ptype;
      logic [7:0]  xid;
      logic [7:0]  hsum;
      logic [15:0] size;
      logic [15:0] remaining;
      logic [15:0] crc;
      bit          skip;

      function new();
         errors = 0;
         beats_seen = 0;
         port_reg = '0;
         proto_reg = '0;
         sync_pattern = '{slp_pkg::PRE_0, slp_pkg::PRE_1, slp_pkg::PRE_2};
         phase = slp_pkg::PH_HUNT;
         pos = '0;
         dest = '0;
         src = '0;
         ptype = '0;
         xid = '0;
         hsum = '0;
         size = '0;
         remaining = '0;
         crc = '0;
         skip = 1'b0;
      endfunction

      function logic [15:0] crc_step(logic [15:0] c_in, logic [7:0] b);
         logic [15:0] c;
         int          k;
         c = c_in ^ {b, 8'h00};
         for (k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ slp_pkg::CRC_POLY) : {c[14:0], 1'b0};
         end
         return c;
      endfunction

      function void write_reg(logic idx, logic [7:0] v);
         if (idx == slp_pkg::REG_LOCAL_PORT) begin
            port_reg = v;
         end else begin
            proto_reg = v;
         end
      endfunction

      function void add_beat(logic kind, logic [7:0] d, logic ok);
         beat_type e;
         e.kind = kind;
         e.data_byte = d;
         e.crc_ok = ok;
         e.source_port = src;
         e.packet_type = ptype;
         e.transaction_id = xid;
         e.body_length = size;
         expected_beats.push_back(e);
      endfunction

      function void note_byte(logic [7:0] b);
         case (phase)
            slp_pkg::PH_HUNT: begin
               if (pos > 4'd2) pos = '0;
               if (b == sync_pattern[pos[1:0]]) begin
                  if (pos == 4'd0) begin
                     hsum = '0;
                     crc = '0;
                  end
                  hsum = hsum + b;
                  crc = crc_step(crc, b);
                  pos = pos + 4'd1;
                  if (pos == slp_pkg::POS_DEST) phase = slp_pkg::PH_HEAD;
               end else begin
                  pos = '0;
               end
            end
            slp_pkg::PH_HEAD: begin
               crc = crc_step(crc, b);
               if (pos < slp_pkg::POS_SUM) hsum = hsum + b;
               case (pos)
                  slp_pkg::POS_DEST:   dest = b;
                  slp_pkg::POS_SRC:    src = b;
                  slp_pkg::POS_TYPE:   ptype = b;
                  slp_pkg::POS_SIZE_H: size[15:8] = b;
                  slp_pkg::POS_SIZE_L: size[7:0] = b;
                  slp_pkg::POS_XID:    xid = b;
                  default: begin
                     if (b != hsum) begin
                        phase = slp_pkg::PH_HUNT;
                     end else begin
                        skip = !(ptype == proto_reg && dest == port_reg);
                        remaining = size;
                        phase = (size != 16'd0) ? slp_pkg::PH_BODY : slp_pkg::PH_CRC;
                     end
                     pos = '0;
                     return;
                  end
               endcase
               pos = pos + 4'd1;
            end
            slp_pkg::PH_BODY: begin
               crc = crc_step(crc, b);
               remaining = remaining - 16'd1;
               if (remaining == 16'd0) begin
                  phase = slp_pkg::PH_CRC;
                  pos = '0;
               end
               if (!skip) add_beat(slp_pkg::KIND_DATA, b, 1'b0);
            end
            default: begin
               crc = crc_step(crc, b);
               pos = pos + 4'd1;
               if (pos >= 4'd2) begin
                  phase = slp_pkg::PH_HUNT;
                  pos = '0;
                  if (!skip) add_beat(slp_pkg::KIND_END, 8'h00, crc == 16'd0);
               end
            end
         endcase
      endfunction

      function void compare(string name, logic [15:0] exp, logic [15:0] act);
         if (exp !== act) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
         end
      endfunction

      function void check_beat(beat_type got);
         beat_type exp;
         beats_seen++;
         if (expected_beats.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, actual kind %0b data %0h",
                     $time, got.kind, got.data_byte);
            return;
         end
         exp = expected_beats.pop_front();
         compare("kind", 16'(exp.kind), 16'(got.kind));
         compare("data_byte", 16'(exp.data_byte), 16'(got.data_byte));
         compare("crc_ok", 16'(exp.crc_ok), 16'(got.crc_ok));
         compare("source_port", 16'(exp.source_port), 16'(got.source_port));
         compare("packet_type", 16'(exp.packet_type), 16'(got.packet_type));
         compare("transaction_id", 16'(exp.transaction_id), 16'(got.transaction_id));
         compare("body_length", exp.body_length, got.body_length);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic        rsp_crc_ok;
   logic [7:0]  rsp_source_port;
   logic [7:0]  rsp_packet_type;
   logic [7:0]  rsp_transaction_id;
   logic [15:0] rsp_body_length;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_wdata = 8'h00;

   logic        calm = 1'b0;
   logic        hold_req = 1'b0;
   bit          hold_done = 1'b0;
   int          hold_left = 0;
   int          bytes_sent = 0;
   deframer_scoreboard_type sb = new();

   slp_packet_deframer_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_crc_ok         (rsp_crc_ok),
      .rsp_source_port    (rsp_source_port),
      .rsp_packet_type    (rsp_packet_type),
      .rsp_transaction_id (rsp_transaction_id),
      .rsp_body_length    (rsp_body_length),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver checks each accepted beat and picks its stall for the next cycle.
   always @(posedge clock) begin : rsp_side
      beat_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = rsp_kind;
         got.data_byte = rsp_data_byte;
         got.crc_ok = rsp_crc_ok;
         got.source_port = rsp_source_port;
         got.packet_type = rsp_packet_type;
         got.transaction_id = rsp_transaction_id;
         got.body_length = rsp_body_length;
         sb.check_beat(got);
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
   end

   task automatic send_byte(logic [7:0] b);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b);
      bytes_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_regs(logic [7:0] port, logic [7:0] proto);
      csr_we <= 1'b1;
      csr_index <= slp_pkg::REG_LOCAL_PORT;
      csr_wdata <= port;
      @(posedge clock);
      sb.write_reg(slp_pkg::REG_LOCAL_PORT, port);
      csr_index <= slp_pkg::REG_LOCAL_PROTOCOL;
      csr_wdata <= proto;
      @(posedge clock);
      sb.write_reg(slp_pkg::REG_LOCAL_PROTOCOL, proto);
      csr_we <= 1'b0;
   endtask

   // A nonzero sum_err sends only the broken header; fill below zero means random body bytes.
   task automatic send_packet(logic [7:0] dest, logic [7:0] ptype, logic [7:0] src,
                              logic [7:0] xid, logic [15:0] size, logic [7:0] sum_err,
                              logic [7:0] crc_err, int fill);
      logic [7:0]  frame[$];
      logic [7:0]  sum;
      logic [15:0] c;
      int          n;
      frame = {slp_pkg::PRE_0, slp_pkg::PRE_1, slp_pkg::PRE_2, dest, src, ptype,
               size[15:8], size[7:0], xid};
      sum = '0;
      foreach (frame[i]) sum = sum + frame[i];
      frame.push_back(sum ^ sum_err);
      if (sum_err == 8'h00) begin
         for (n = 0; n < size; n++) begin
            frame.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
         end
         c = '0;
         foreach (frame[i]) c = sb.crc_step(c, frame[i]);
         frame.push_back(c[15:8] ^ crc_err);
         frame.push_back(c[7:0]);
      end
      foreach (frame[i]) send_byte(frame[i]);
   endtask

   task automatic random_packet();
      int          pick;
      logic [7:0]  dest;
      logic [7:0]  ptype;
      logic [7:0]  sum_err;
      logic [7:0]  crc_err;
      logic [15:0] size;
      pick = $urandom_range(99);
      dest = sb.port_reg;
      ptype = sb.proto_reg;
      sum_err = 8'h00;
      crc_err = 8'h00;
      if (pick < 6) begin
         dest = dest ^ 8'($urandom_range(1, 255));
      end else if (pick < 12) begin
         ptype = ptype ^ 8'($urandom_range(1, 255));
      end else if (pick < 18) begin
         sum_err = 8'($urandom_range(1, 255));
      end else if (pick < 24) begin
         crc_err = 8'($urandom_range(1, 255));
      end else if (pick < 28) begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (pick < 31) begin
         send_byte(slp_pkg::PRE_0);
         send_byte(slp_pkg::PRE_1);
         send_byte(8'($urandom));
      end
      size = ($urandom_range(9) == 0) ? 16'($urandom_range(9, 40)) : 16'($urandom_range(0, 6));
      send_packet(dest, ptype, 8'($urandom), 8'($urandom), size, sum_err, crc_err, -1);
   endtask

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int round;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Registers still at reset, so a packet for port zero, type zero is accepted.
      send_packet(8'h00, 8'h00, 8'h5a, 8'h01, 16'd0, 8'h00, 8'h00, -1);
      drain();
      set_regs(8'h12, 8'h34);
      // A repeated first preamble byte is dropped, not taken as a new start.
      send_byte(slp_pkg::PRE_0);
      send_byte(slp_pkg::PRE_0);
      send_byte(slp_pkg::PRE_1);
      send_byte(slp_pkg::PRE_2);
      send_byte(slp_pkg::PRE_0);
      send_byte(slp_pkg::PRE_1);
      send_byte(8'h00);
      send_packet(8'h12, 8'h34, 8'hff, 8'hff, 16'd4, 8'h00, 8'h00, 8'h00);
      send_packet(8'h12, 8'h34, 8'h00, 8'h80, 16'd3, 8'h00, 8'h00, 8'hff);
      send_packet(8'h12, 8'h34, 8'h11, 8'h22, 16'hffff, 8'h01, 8'h00, -1);
      send_packet(8'h12, 8'h34, 8'h33, 8'h44, 16'd0, 8'h00, 8'h00, -1);
      send_packet(8'h13, 8'h34, 8'h55, 8'h66, 16'd5, 8'h00, 8'h00, -1);
      send_packet(8'h12, 8'h35, 8'h77, 8'h88, 16'd5, 8'h00, 8'h00, -1);
      send_packet(8'h12, 8'h34, 8'h99, 8'haa, 16'd5, 8'h00, 8'h80, -1);
      drain();
      set_regs(8'hff, 8'hff);
      send_packet(8'hff, 8'hff, 8'hc3, 8'h3c, 16'd2, 8'h00, 8'h00, -1);

      round = 0;
      while (bytes_sent < ITEM_GOAL || sb.beats_seen < BEAT_GOAL) begin
         drain();
         case (round)
            0: set_regs(8'hff, 8'h00);
            1: set_regs(8'h00, 8'hff);
            default: set_regs(8'($urandom), 8'($urandom));
         endcase
         calm <= (round == 1);
         if (round == 2) begin
            // The receiver holds off while a long body streams in, so the input backs up.
            hold_req <= 1'b1;
            send_packet(sb.port_reg, sb.proto_reg, 8'($urandom), 8'($urandom), 16'd30,
                        8'h00, 8'h00, -1);
         end
         if (round == 3) begin
            send_packet(sb.port_reg, sb.proto_reg, 8'($urandom), 8'($urandom), 16'h0103,
                        8'h00, 8'h00, -1);
         end
         repeat (8) random_packet();
         round++;
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/slp_pkg.sv
hw/rtl/slp_crc16.sv
hw/rtl/slp_packet_deframer_top.sv
hw/rtl/slp_checker.sv
bench/slp_packet_deframer_top_test.sv
